/* design/sstoi_pkg.sv */
package sstoi_pkg;

  // Fixed field layout.
  localparam int CompBits  = 21;
  localparam int VecBits   = 63;
  localparam int RadBits   = 20;
  localparam int TimeBits  = 24;
  localparam int FracBits  = 16;
  localparam int CfgBits   = 32;
  localparam int PaddrBits = 3;

  // Derived arithmetic widths.
  localparam int DiffBits  = CompBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int RsumBits  = RadBits + 1;
  localparam int RsqBits   = 2 * RsumBits;
  localparam int SumBits   = ProdBits;
  localparam int HalfBits  = SumBits / 2;
  localparam int WideBits  = 2 * SumBits;
  localparam int RootBits  = SumBits;

  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = 2;

  localparam logic [TimeBits-1:0] ResetInterval = TimeBits'(65536);
  localparam logic RegIntervalIdx = 1'b0;

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic signed [DiffBits-1:0] diff_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [SumBits:0]    ssum_t;
  typedef logic [SumBits-1:0]         mag_t;
  typedef logic [WideBits-1:0]        wide_t;

  typedef enum logic [1:0] {
    KIND_TOUCH,
    KIND_MISS,
    KIND_SOLVE
  } kind_e;

  typedef struct packed {
    logic [VecBits-1:0] start_pos_a;
    logic [VecBits-1:0] velocity_a;
    logic [VecBits-1:0] start_pos_b;
    logic [VecBits-1:0] velocity_b;
    logic [RadBits-1:0] radius_a;
    logic [RadBits-1:0] radius_b;
  } in_req_t;

  typedef struct packed {
    logic                hit;
    logic [TimeBits-1:0] impact_time;
  } out_rsp_t;

  typedef struct packed {
    kind_e kind;
    mag_t  mag_h;
    mag_t  a;
    mag_t  c;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic comp_t comp(input logic [VecBits-1:0] vec, input logic [1:0] idx);
    comp_t res;
    res = vec[idx*CompBits +: CompBits];
    return res;
  endfunction

endpackage

/* design/sstoi_front.sv */
module sstoi_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sstoi_pkg::in_req_t in_req_i,
  input  sstoi_pkg::qstat_t  qstat_i,
  output logic               push_o,
  output sstoi_pkg::qentry_t entry_o
);

  logic front_en, accept;
  logic v1_q, v2_q, v3_q;

  sstoi_pkg::diff_t p_d [3], u_d [3];
  sstoi_pkg::diff_t p_q [3], u_q [3];
  logic [sstoi_pkg::RsumBits-1:0] rs_d, rs_q;

  sstoi_pkg::prod_t pp_q [3], uu_q [3], pu_q [3];
  logic [sstoi_pkg::RsqBits-1:0] rr_q;

  sstoi_pkg::ssum_t c_q, a_q, h_q;

  // The whole front freezes only when its last stage cannot hand off.
  assign front_en   = !(v3_q && qstat_i.full);
  assign in_stall_o = !front_en;
  assign accept     = in_valid_i && front_en;
  assign push_o     = v3_q && front_en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_d[i] = sstoi_pkg::diff_t'(sstoi_pkg::comp(in_req_i.start_pos_a, 2'(i)))
             - sstoi_pkg::diff_t'(sstoi_pkg::comp(in_req_i.start_pos_b, 2'(i)));
      u_d[i] = sstoi_pkg::diff_t'(sstoi_pkg::comp(in_req_i.velocity_a, 2'(i)))
             - sstoi_pkg::diff_t'(sstoi_pkg::comp(in_req_i.velocity_b, 2'(i)));
    end
    rs_d = {1'b0, in_req_i.radius_a} + {1'b0, in_req_i.radius_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (front_en) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i]  <= p_d[i];
        u_q[i]  <= u_d[i];
        pp_q[i] <= p_q[i] * p_q[i];
        uu_q[i] <= u_q[i] * u_q[i];
        pu_q[i] <= p_q[i] * u_q[i];
      end
      rs_q <= rs_d;
      rr_q <= rs_q * rs_q;
      c_q  <= sstoi_pkg::ssum_t'(pp_q[0]) + sstoi_pkg::ssum_t'(pp_q[1])
            + sstoi_pkg::ssum_t'(pp_q[2]) - sstoi_pkg::ssum_t'(rr_q);
      a_q  <= sstoi_pkg::ssum_t'(uu_q[0]) + sstoi_pkg::ssum_t'(uu_q[1])
            + sstoi_pkg::ssum_t'(uu_q[2]);
      h_q  <= sstoi_pkg::ssum_t'(pu_q[0]) + sstoi_pkg::ssum_t'(pu_q[1])
            + sstoi_pkg::ssum_t'(pu_q[2]);
    end
  end

  always_comb begin
    sstoi_pkg::ssum_t neg_h;
    neg_h         = -h_q;
    entry_o.mag_h = sstoi_pkg::mag_t'(neg_h);
    entry_o.a     = sstoi_pkg::mag_t'(a_q);
    entry_o.c     = sstoi_pkg::mag_t'(c_q);
    if (c_q <= 0) begin
      entry_o.kind = sstoi_pkg::KIND_TOUCH;
    end else if (a_q == 0 || h_q >= 0) begin
      entry_o.kind = sstoi_pkg::KIND_MISS;
    end else begin
      entry_o.kind = sstoi_pkg::KIND_SOLVE;
    end
  end

endmodule

/* design/sstoi_queue.sv */
module sstoi_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sstoi_pkg::qentry_t wdata_i,
  input  logic               pop_i,
  output sstoi_pkg::qentry_t rdata_o,
  output sstoi_pkg::qstat_t  qstat_o
);

  sstoi_pkg::qentry_t mem_q [sstoi_pkg::QueueDepth];
  logic [sstoi_pkg::QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [sstoi_pkg::QueuePtrBits:0]   count_q;

  assign qstat_o.full  = (count_q == (sstoi_pkg::QueuePtrBits+1)'(sstoi_pkg::QueueDepth));
  assign qstat_o.empty = (count_q == '0);
  assign rdata_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* design/sstoi_back.sv */
module sstoi_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sstoi_pkg::qstat_t               qstat_i,
  output logic                            pop_o,
  input  sstoi_pkg::qentry_t              entry_i,
  input  logic [sstoi_pkg::TimeBits-1:0]  interval_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sstoi_pkg::out_rsp_t             out_rsp_o
);

  localparam int RemBits  = sstoi_pkg::RootBits + 3;
  localparam int NumBits  = sstoi_pkg::SumBits + sstoi_pkg::FracBits;
  localparam int HalfBits = sstoi_pkg::HalfBits;
  localparam int SumBits  = sstoi_pkg::SumBits;
  localparam int TimeBits = sstoi_pkg::TimeBits;
  localparam int RootBits = sstoi_pkg::RootBits;
  localparam int WideBits = sstoi_pkg::WideBits;

  typedef struct packed {
    sstoi_pkg::kind_e kind;
    sstoi_pkg::mag_t  a;
    sstoi_pkg::mag_t  mag_h;
  } ctx_t;

  typedef struct packed {
    sstoi_pkg::kind_e      kind;
    sstoi_pkg::mag_t       a;
    sstoi_pkg::mag_t       mag_h;
    sstoi_pkg::wide_t      rad;
    logic [RemBits-1:0]    rem;
    sstoi_pkg::mag_t       root;
  } sq_t;

  typedef struct packed {
    sstoi_pkg::kind_e      kind;
    sstoi_pkg::mag_t       a;
    sstoi_pkg::mag_t       rem;
    logic [TimeBits-1:0]   lo;
    logic [TimeBits-1:0]   q;
  } dv_t;

  logic back_en;

  // Partial products of h*h and a*c.
  logic b1_vld_q, b2_vld_q, b3_vld_q, b4_vld_q;
  ctx_t b1_ctx_q, b2_ctx_q, b3_ctx_q;
  logic [2*HalfBits-1:0] hp_q [4], ap_q [4];
  sstoi_pkg::wide_t hh_q, ac_q, d_q;

  sq_t  sq_in;
  sq_t  sq_q [RootBits];
  logic sq_vld_q [RootBits];

  dv_t  dv_in_q;
  dv_t  dv_q [TimeBits];
  logic dv_vld_q [TimeBits];

  logic out_vld_q;
  sstoi_pkg::out_rsp_t out_q, out_d;

  // The back advances as one unit; it holds only while a result waits.
  assign back_en     = !(out_vld_q && out_stall_i);
  assign pop_o       = back_en && !qstat_i.empty;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      b4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (back_en) begin
      b1_vld_q  <= pop_o;
      b2_vld_q  <= b1_vld_q;
      b3_vld_q  <= b2_vld_q;
      b4_vld_q  <= sq_vld_q[RootBits-1];
      out_vld_q <= dv_vld_q[TimeBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      b1_ctx_q.kind  <= entry_i.kind;
      b1_ctx_q.a     <= entry_i.a;
      b1_ctx_q.mag_h <= entry_i.mag_h;
      hp_q[3] <= entry_i.mag_h[SumBits-1:HalfBits] * entry_i.mag_h[SumBits-1:HalfBits];
      hp_q[2] <= entry_i.mag_h[SumBits-1:HalfBits] * entry_i.mag_h[HalfBits-1:0];
      hp_q[1] <= entry_i.mag_h[HalfBits-1:0] * entry_i.mag_h[SumBits-1:HalfBits];
      hp_q[0] <= entry_i.mag_h[HalfBits-1:0] * entry_i.mag_h[HalfBits-1:0];
      ap_q[3] <= entry_i.a[SumBits-1:HalfBits] * entry_i.c[SumBits-1:HalfBits];
      ap_q[2] <= entry_i.a[SumBits-1:HalfBits] * entry_i.c[HalfBits-1:0];
      ap_q[1] <= entry_i.a[HalfBits-1:0] * entry_i.c[SumBits-1:HalfBits];
      ap_q[0] <= entry_i.a[HalfBits-1:0] * entry_i.c[HalfBits-1:0];

      b2_ctx_q <= b1_ctx_q;
      hh_q <= (sstoi_pkg::wide_t'(hp_q[3]) << (2*HalfBits))
            + (sstoi_pkg::wide_t'(hp_q[2]) << HalfBits)
            + (sstoi_pkg::wide_t'(hp_q[1]) << HalfBits)
            + sstoi_pkg::wide_t'(hp_q[0]);
      ac_q <= (sstoi_pkg::wide_t'(ap_q[3]) << (2*HalfBits))
            + (sstoi_pkg::wide_t'(ap_q[2]) << HalfBits)
            + (sstoi_pkg::wide_t'(ap_q[1]) << HalfBits)
            + sstoi_pkg::wide_t'(ap_q[0]);

      // A negative discriminant means the paths never meet.
      b3_ctx_q.a     <= b2_ctx_q.a;
      b3_ctx_q.mag_h <= b2_ctx_q.mag_h;
      b3_ctx_q.kind  <= (b2_ctx_q.kind == sstoi_pkg::KIND_SOLVE && ac_q > hh_q) ?
                        sstoi_pkg::KIND_MISS : b2_ctx_q.kind;
      d_q <= hh_q - ac_q;
    end
  end

  always_comb begin
    sq_in.kind  = b3_ctx_q.kind;
    sq_in.a     = b3_ctx_q.a;
    sq_in.mag_h = b3_ctx_q.mag_h;
    sq_in.rad   = d_q;
    sq_in.rem   = '0;
    sq_in.root  = '0;
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < RootBits; k++) begin : g_sqrt
    sq_t prev, nxt;
    logic prev_v;
    logic [RemBits-1:0] rem_sh, trial;
    logic ge;

    if (k == 0) begin : g_first
      assign prev   = sq_in;
      assign prev_v = b3_vld_q;
    end else begin : g_next
      assign prev   = sq_q[k-1];
      assign prev_v = sq_vld_q[k-1];
    end

    always_comb begin
      rem_sh   = {prev.rem[RemBits-3:0], prev.rad[WideBits-1 -: 2]};
      trial    = RemBits'({prev.root, 2'b01});
      ge       = (rem_sh >= trial);
      nxt      = prev;
      nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
      nxt.root = {prev.root[RootBits-2:0], ge};
      nxt.rad  = prev.rad << 2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (back_en) begin
        sq_vld_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (back_en) begin
        sq_q[k] <= nxt;
      end
    end
  end

  // Build the numerator and rule out quotients that cannot fit the time field.
  always_ff @(posedge clk_i) begin
    sstoi_pkg::mag_t     s, diff;
    logic [NumBits-1:0]  num;
    sstoi_pkg::mag_t     hi;
    if (back_en) begin
      s    = (sq_q[RootBits-1].root > sq_q[RootBits-1].mag_h) ?
             sq_q[RootBits-1].mag_h : sq_q[RootBits-1].root;
      diff = sq_q[RootBits-1].mag_h - s;
      num  = {diff, {sstoi_pkg::FracBits{1'b0}}};
      hi   = SumBits'(num[NumBits-1:TimeBits]);
      dv_in_q.kind <= (sq_q[RootBits-1].kind == sstoi_pkg::KIND_SOLVE &&
                       hi >= sq_q[RootBits-1].a) ?
                      sstoi_pkg::KIND_MISS : sq_q[RootBits-1].kind;
      dv_in_q.a   <= sq_q[RootBits-1].a;
      dv_in_q.rem <= hi;
      dv_in_q.lo  <= num[TimeBits-1:0];
      dv_in_q.q   <= '0;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < TimeBits; k++) begin : g_div
    dv_t prev, nxt;
    logic prev_v;
    logic [SumBits:0] rem_sh;
    logic ge;

    if (k == 0) begin : g_first
      assign prev   = dv_in_q;
      assign prev_v = b4_vld_q;
    end else begin : g_next
      assign prev   = dv_q[k-1];
      assign prev_v = dv_vld_q[k-1];
    end

    always_comb begin
      rem_sh  = {prev.rem, prev.lo[TimeBits-1]};
      ge      = (rem_sh >= {1'b0, prev.a});
      nxt     = prev;
      nxt.rem = ge ? SumBits'(rem_sh - {1'b0, prev.a}) : SumBits'(rem_sh);
      nxt.q   = {prev.q[TimeBits-2:0], ge};
      nxt.lo  = prev.lo << 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (back_en) begin
        dv_vld_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (back_en) begin
        dv_q[k] <= nxt;
      end
    end
  end

  always_comb begin
    out_d.hit         = 1'b0;
    out_d.impact_time = '0;
    case (dv_q[TimeBits-1].kind)
      sstoi_pkg::KIND_TOUCH: begin
        out_d.hit = 1'b1;
      end
      sstoi_pkg::KIND_SOLVE: begin
        if (dv_q[TimeBits-1].q <= interval_i) begin
          out_d.hit         = 1'b1;
          out_d.impact_time = dv_q[TimeBits-1].q;
        end
      end
      default: begin
        out_d.hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      out_q <= out_d;
    end
  end

endmodule

/* design/sphere_sweep_time_of_impact.sv */
// Time of impact for two spheres sweeping along straight lines.
//
// Each request on the input channel carries both start positions, both
// velocities and both radii. It is taken at a clock edge where in_valid_i
// is high and in_stall_o is low. One response per request comes out on the
// output channel, in request order, and is taken where out_valid_o is high
// and out_stall_i is low. The response says whether the spheres touch within
// the interval set in the interval_length register, and when.
//
// A new request can be taken every cycle while in_stall_o is low. Each
// response passes through three front stages that compute the dot
// products, then a four-entry queue, three stages of split multiplies,
// 44 square-root stages (one root bit each), one setup stage,
// 24 divider stages (one quotient bit each) and the output register.
// When the receiver stalls, the back pipeline holds its contents and the
// queue fills; once it is full, in_stall_o rises and the front holds too.
// Reset empties the pipelines and the queue and sets interval_length to
// one time unit (65536). Write interval_length only while the block is idle.
module sphere_sweep_time_of_impact (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sstoi_pkg::in_req_t                in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sstoi_pkg::out_rsp_t               out_rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sstoi_pkg::PaddrBits-1:0]   paddr,
  input  logic [sstoi_pkg::CfgBits-1:0]     pwdata,
  output logic [sstoi_pkg::CfgBits-1:0]     prdata,
  output logic                              pready
);

  logic [sstoi_pkg::TimeBits-1:0] interval_q;
  logic                           reg_sel;

  logic               push, pop;
  sstoi_pkg::qentry_t push_entry, pop_entry;
  sstoi_pkg::qstat_t  qstat;

  // Register index is the word address; byte offsets are ignored.
  assign reg_sel = (paddr[sstoi_pkg::PaddrBits-1] == sstoi_pkg::RegIntervalIdx);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? sstoi_pkg::CfgBits'(interval_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= sstoi_pkg::ResetInterval;
    end else if (psel && penable && pwrite && reg_sel) begin
      interval_q <= pwdata[sstoi_pkg::TimeBits-1:0];
    end
  end

  // The front classifies each pair; only approaching pairs need the root.
  sstoi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sstoi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .qstat_o (qstat)
  );

  // The back solves the quadratic and compares against the interval.
  sstoi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .entry_i     (pop_entry),
    .interval_i  (interval_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* design/sstoi_checker.sv */
module sstoi_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input sstoi_pkg::in_req_t                in_req_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input sstoi_pkg::out_rsp_t               out_rsp_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [sstoi_pkg::PaddrBits-1:0]   paddr,
  input logic [sstoi_pkg::CfgBits-1:0]     pwdata,
  input logic [sstoi_pkg::CfgBits-1:0]     prdata,
  input logic                              pready
);

  // A stalled response stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // A miss always reports time zero.
  a_miss_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.hit |-> out_rsp_o.impact_time == '0)
    else $error("miss with nonzero time");

  // With the receiver ready, the queue drains enough to take a request in the next cycle.
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> !in_stall_o)
    else $error("input stalled although output drained");

  // The interval register reads back what was written.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[sstoi_pkg::PaddrBits-1])
    ##1 (psel && !pwrite && !paddr[sstoi_pkg::PaddrBits-1])
    |-> prdata[sstoi_pkg::TimeBits-1:0] == $past(pwdata[sstoi_pkg::TimeBits-1:0]))
    else $error("interval readback mismatch");

endmodule

bind sphere_sweep_time_of_impact sstoi_checker u_checker (.*);
